/* hw/rtl/tws_pkg.sv */
// Shared types and constants for the theremin wavetable synthesizer.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package tws_pkg;

    localparam int WAVE_DEPTH_DEF    = 4096;
    localparam int PITCH_TABLE_DEPTH = 2048;
    localparam int VOL_TABLE_DEPTH   = 1024;
    localparam int SHAPE_TABLE_DEPTH = 1025;

    // item opcodes
    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_LOAD_PITCH = 3'd1;
    localparam logic [2:0] OP_LOAD_VOL   = 3'd2;
    localparam logic [2:0] OP_LOAD_WAVE  = 3'd3;
    localparam logic [2:0] OP_LOAD_SHAPE = 3'd4;

    // config register indexes
    localparam logic [1:0] CFG_PITCH_OFFSET = 2'd0;
    localparam logic [1:0] CFG_VOL_OFFSET   = 2'd1;
    localparam logic [1:0] CFG_WAVE_LOG2    = 2'd2;
    localparam logic [1:0] CFG_USE_SHAPING  = 2'd3;

    // sequencer steps
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_LOD    = 5'd1;
    localparam logic [4:0] ST_FRAC   = 5'd2;
    localparam logic [4:0] ST_RDA    = 5'd3;
    localparam logic [4:0] ST_RDB    = 5'd4;
    localparam logic [4:0] ST_MULB   = 5'd5;
    localparam logic [4:0] ST_ACC    = 5'd6;
    localparam logic [4:0] ST_WRA    = 5'd7;
    localparam logic [4:0] ST_WRB    = 5'd8;
    localparam logic [4:0] ST_WMUL   = 5'd9;
    localparam logic [4:0] ST_INTERP = 5'd10;
    localparam logic [4:0] ST_VMUL   = 5'd11;
    localparam logic [4:0] ST_WAV    = 5'd12;
    localparam logic [4:0] ST_SRA    = 5'd13;
    localparam logic [4:0] ST_SRB    = 5'd14;
    localparam logic [4:0] ST_SMUL   = 5'd15;
    localparam logic [4:0] ST_OUT    = 5'd16;

    typedef struct packed {
        logic [4:0] step;
        logic       accept;
        logic       out_load;
    } t_cmd;

endpackage
`default_nettype wire

/* hw/rtl/tws_ctrl.sv */
// Sequencer for the theremin synthesizer: steps a tick through the datapath.
// Depends on tws_pkg.
`default_nettype none
module tws_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [2:0]  i_op,
    output logic             o_stall,
    output logic             o_valid,
    input  wire logic        i_stall,
    output tws_pkg::t_cmd    o_cmd
);
    import tws_pkg::*;

    logic [4:0] r_state, n_state;
    logic       r_valid, n_valid;
    logic       accept, out_load;

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_load = (r_state == ST_OUT) && (!r_valid || !i_stall);

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = (accept && i_op == OP_TICK) ? ST_LOD : ST_IDLE;
            ST_OUT:  n_state = out_load ? ST_IDLE : ST_OUT;
            default: n_state = r_state + 5'd1;
        endcase
        n_valid = out_load || (r_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_valid        = r_valid;
    assign o_cmd.step     = r_state;
    assign o_cmd.accept   = accept;
    assign o_cmd.out_load = out_load;
endmodule
`default_nettype wire

/* hw/rtl/tws_datapath.sv */
// Datapath of the theremin synthesizer: config registers, tables, filters, DDS.
// Depends on tws_pkg; driven by tws_ctrl commands.
`default_nettype none
module tws_datapath #(
    parameter int WAVE_DEPTH = tws_pkg::WAVE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tws_pkg::t_cmd       i_cmd,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data,
    input  wire logic [2:0]          i_op,
    input  wire logic [11:0]         i_table_index,
    input  wire logic [31:0]         i_table_data,
    input  wire logic [15:0]         i_pitch_capture,
    input  wire logic [15:0]         i_vol_capture,
    output logic signed [15:0]       o_dac_sample
);
    import tws_pkg::*;

    localparam int WAW = $clog2(WAVE_DEPTH);

    function automatic logic [4:0] lod32(input logic [31:0] v);
        logic [4:0] e;
        e = 5'd0;
        for (int i = 1; i < 32; i++) begin
            if (v[i]) e = 5'(i);
        end
        return e;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh07FFFFFFF)       r = 32'sh7FFFFFFF;
        else if (v < -36'sh080000000) r = 32'sh80000000;
        else                          r = v[31:0];
        return r;
    endfunction

    // period to filter target, saturated; zero flag reported separately
    function automatic logic [31:0] to_target(input logic [15:0] dbl);
        logic signed [15:0] s;
        logic [31:0]        t;
        s = $signed(dbl - 16'd2048);
        if (s > 16'sd2047)       t = 32'h7FFFFFFF;
        else if (s < -16'sd2048) t = 32'h80000000;
        else                     t = {s[11:0], 20'd0};
        return t;
    endfunction

    // memories
    logic [28:0]        pitch_mem [PITCH_TABLE_DEPTH];
    logic [9:0]         vol_mem   [VOL_TABLE_DEPTH];
    logic [15:0]        wave_mem  [WAVE_DEPTH];
    logic [15:0]        shape_mem [SHAPE_TABLE_DEPTH];

    // config
    logic signed [31:0] r_pitch_offset, r_vol_offset;
    logic [3:0]         r_wave_log2;
    logic               r_use_shaping;

    // persistent state
    logic [15:0]        r_last_ps, r_last_vs, r_ps_in, r_vs_in;
    logic signed [31:0] r_pf, r_vf, r_pv;
    logic signed [19:0] r_vv;
    logic [31:0]        r_phase;
    logic [21:0]        r_vacc;
    logic [10:0]        r_vsm;

    // working registers
    logic [31:0]        r_p;
    logic               r_ppos;
    logic [4:0]         r_pe;
    logic [14:0]        r_vc;
    logic [3:0]         r_ve;
    logic [10:0]        r_pti;
    logic [14:0]        r_pw;
    logic [9:0]         r_vti;
    logic [16:0]        r_vw;
    logic [28:0]        r_prd;
    logic [9:0]         r_vrd;
    logic [45:0]        r_pm0, r_pm1;
    logic [27:0]        r_vm0, r_vm1;
    logic [15:0]        r_wrd, r_wa;
    logic signed [25:0] r_wprod0;
    logic signed [16:0] r_interp;
    logic signed [28:0] r_wprod1;
    logic signed [17:0] r_wav;
    logic               r_uneg;
    logic [10:0]        r_sti;
    logic [5:0]         r_sw;
    logic [15:0]        r_srd, r_sa;
    logic signed [23:0] r_sprod;
    logic [31:0]        r_ptgt, r_vtgt;
    logic               r_pzero, r_vzero;
    logic signed [31:0] r_pdiff, r_vdiff, r_pt, r_vt;

    logic [4:0] step;
    assign step = i_cmd.step;

    // ---------------- combinational helpers ----------------
    logic [14:0]        vclamp;
    logic [4:0]         ve_full;
    logic [31:0]        psh, vsh;
    logic [45:0]        psum;
    logic [27:0]        vsum;
    logic [21:0]        vacc_n;
    logic [3:0]         lg;
    logic [12:0]        mask;
    logic [11:0]        wti, wti1, waddr;
    logic signed [25:0] wq;
    logic signed [28:0] wavq;
    logic signed [18:0] u;
    logic [10:0]        saddr;
    logic               sa_ok, sb_ok;
    logic signed [16:0] sb17, sa17;
    logic signed [24:0] snum, sq;
    logic signed [18:0] sel;
    logic signed [15:0] sat_out;
    logic [15:0]        pper, vper, pdbl, vdbl;
    logic [10:0]        p_addr;
    logic [9:0]         v_addr;
    logic signed [32:0] pq, vq;
    logic signed [34:0] pv8;

    always_comb begin
        if ($signed(r_vv) < 20'sd1)          vclamp = 15'd1;
        else if ($signed(r_vv) > 20'sd32767) vclamp = 15'd32767;
        else                                 vclamp = r_vv[14:0];
        ve_full = lod32({17'd0, vclamp});

        psh = r_p << (5'd31 - r_pe);
        vsh = {17'd0, r_vc} << (5'd31 - {1'b0, r_ve});

        p_addr = (step == ST_RDB) ? r_pti + 11'd1 : r_pti;
        v_addr = (step == ST_RDB) ? r_vti + 10'd1 : r_vti;

        psum   = r_pm0 + r_pm1;
        vsum   = r_vm0 + r_vm1;
        vacc_n = r_vacc + {12'd0, vsum[26:17]} - {11'd0, r_vsm};

        lg    = (r_wave_log2 > 4'd12) ? 4'd12 : r_wave_log2;
        mask  = ((13'd1 << lg) - 13'd1) & 13'(WAVE_DEPTH - 1);
        wti   = r_phase[31:20];
        wti1  = wti + 12'd1;
        waddr = ((step == ST_WRB) ? wti1 : wti) & mask[11:0];

        // truncating divides
        wq   = (r_wprod0 + (r_wprod0 < 0 ? 26'sd255 : 26'sd0)) >>> 8;
        wavq = (r_wprod1 + (r_wprod1 < 0 ? 29'sd1023 : 29'sd0)) >>> 10;
        u    = $signed({wavq[17], wavq[17:0]}) + 19'sd32768;

        sa_ok = !r_uneg && (r_sti < 11'(SHAPE_TABLE_DEPTH));
        sb_ok = !r_uneg && ((r_sti + 11'd1) < 11'(SHAPE_TABLE_DEPTH));
        if (step == ST_SRB) saddr = sb_ok ? r_sti + 11'd1 : 11'd0;
        else                saddr = sa_ok ? r_sti : 11'd0;

        sa17 = $signed({r_sa[15], r_sa});
        sb17 = sb_ok ? $signed({r_srd[15], r_srd}) : 17'sd0;
        snum = $signed({{3{r_sa[15]}}, r_sa, 6'd0}) + $signed({r_sprod[23], r_sprod});
        sq   = (snum + (snum < 0 ? 25'sd63 : 25'sd0)) >>> 6;
        sel  = r_use_shaping ? sq[18:0] : $signed({r_wav[17], r_wav});
        if (sel > 19'sd32767)       sat_out = 16'sh7FFF;
        else if (sel < -19'sd32768) sat_out = 16'sh8000;
        else                        sat_out = sel[15:0];

        pper = r_ps_in - r_last_ps;
        vper = r_vs_in - r_last_vs;
        pdbl = (pper < 16'd2000) ? {pper[14:0], 1'b0} : pper;
        vdbl = (vper < 16'd2000) ? {vper[14:0], 1'b0} : vper;

        pq  = ($signed({r_pdiff[31], r_pdiff}) + (r_pdiff < 0 ? 33'sd1023 : 33'sd0)) >>> 10;
        vq  = ($signed({r_vdiff[31], r_vdiff}) + (r_vdiff < 0 ? 33'sd1023 : 33'sd0)) >>> 10;
        pv8 = {r_pt[31], r_pt[31], r_pt[31], r_pt} <<< 3;
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_op == OP_LOAD_PITCH && !i_table_index[11])
            pitch_mem[i_table_index[10:0]] <= i_table_data[28:0];
        r_prd <= pitch_mem[p_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_op == OP_LOAD_VOL && i_table_index[11:10] == 2'd0)
            vol_mem[i_table_index[9:0]] <= i_table_data[9:0];
        r_vrd <= vol_mem[v_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_op == OP_LOAD_WAVE
            && {1'b0, i_table_index} < 13'(WAVE_DEPTH))
            wave_mem[i_table_index[WAW-1:0]] <= i_table_data[15:0];
        r_wrd <= wave_mem[waddr[WAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_op == OP_LOAD_SHAPE
            && i_table_index < 12'(SHAPE_TABLE_DEPTH))
            shape_mem[i_table_index[10:0]] <= i_table_data[15:0];
        r_srd <= shape_mem[saddr];
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_offset <= '0;
            r_vol_offset   <= '0;
            r_wave_log2    <= 4'd12;
            r_use_shaping  <= 1'b0;
            r_last_ps      <= '0;
            r_last_vs      <= '0;
            r_pf           <= '0;
            r_vf           <= '0;
            r_pv           <= '0;
            r_vv           <= '0;
            r_phase        <= '0;
            r_vacc         <= '0;
            r_vsm          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PITCH_OFFSET: r_pitch_offset <= i_cfg_data;
                    CFG_VOL_OFFSET:   r_vol_offset   <= i_cfg_data;
                    CFG_WAVE_LOG2:    r_wave_log2    <= i_cfg_data[3:0];
                    CFG_USE_SHAPING:  r_use_shaping  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (step == ST_ACC) begin
                if (r_ppos) r_phase <= r_phase + {1'b0, psum[45:15]};
                r_vacc <= vacc_n;
                r_vsm  <= vacc_n[20:10];
            end
            if (step == ST_WMUL) begin
                if (!r_pzero)
                    r_pf <= sat32({{4{r_pf[31]}}, r_pf} + {{3{pq[32]}}, pq});
                if (!r_vzero)
                    r_vf <= sat32({{4{r_vf[31]}}, r_vf} + {{3{vq[32]}}, vq});
                r_last_ps <= r_ps_in;
                r_last_vs <= r_vs_in;
            end
            if (step == ST_VMUL) begin
                r_pv <= sat32({pv8[34], pv8});
                r_vv <= 20'((r_vt + (r_vt < 0 ? 32'sd4095 : 32'sd0)) >>> 12);
            end
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ps_in <= i_pitch_capture;
            r_vs_in <= i_vol_capture;
        end
        case (step)
            ST_LOD: begin
                r_p    <= r_pv;
                r_ppos <= !r_pv[31] && (r_pv != 32'sd0);
                r_pe   <= lod32(r_pv);
                r_vc   <= vclamp;
                r_ve   <= ve_full[3:0];
            end
            ST_FRAC: begin
                r_pti <= {r_pe[4:0], psh[30:25]};
                r_pw  <= psh[24:10];
                r_vti <= {r_ve, vsh[30:25]};
                r_vw  <= vsh[24:8];
            end
            ST_RDB: begin
                r_pm0 <= r_prd * (17'd32768 - {2'd0, r_pw});
                r_vm0 <= r_vrd * (18'd131072 - {1'b0, r_vw});
            end
            ST_MULB: begin
                r_pm1 <= r_prd * r_pw;
                r_vm1 <= r_vrd * r_vw;
            end
            ST_WRA: begin
                r_ptgt  <= to_target(pdbl);
                r_vtgt  <= to_target(vdbl);
                r_pzero <= (pdbl == 16'd0);
                r_vzero <= (vdbl == 16'd0);
            end
            ST_WRB: begin
                r_wa    <= r_wrd;
                r_pdiff <= sat32($signed({{4{r_ptgt[31]}}, r_ptgt}) - {{4{r_pf[31]}}, r_pf});
                r_vdiff <= sat32($signed({{4{r_vtgt[31]}}, r_vtgt}) - {{4{r_vf[31]}}, r_vf});
            end
            ST_WMUL: begin
                r_wprod0 <= ($signed({r_wrd[15], r_wrd}) - $signed({r_wa[15], r_wa}))
                            * $signed({1'b0, r_phase[19:12]});
            end
            ST_INTERP: begin
                r_interp <= $signed({r_wa[15], r_wa}) + wq[16:0];
                r_pt     <= sat32({{4{r_pf[31]}}, r_pf} - {{4{r_pitch_offset[31]}}, r_pitch_offset});
                r_vt     <= sat32({{4{r_vf[31]}}, r_vf} - {{4{r_vol_offset[31]}}, r_vol_offset});
            end
            ST_VMUL: begin
                r_wprod1 <= r_interp * $signed({1'b0, r_vsm});
            end
            ST_WAV: begin
                r_wav  <= wavq[17:0];
                r_uneg <= u[18];
                r_sti  <= u[16:6];
                r_sw   <= u[5:0];
            end
            ST_SRB: begin
                r_sa <= sa_ok ? r_srd : 16'd0;
            end
            ST_SMUL: begin
                r_sprod <= (sb17 - sa17) * $signed({1'b0, r_sw});
            end
            default: ;
        endcase
        if (i_cmd.out_load) o_dac_sample <= sat_out;
    end
endmodule
`default_nettype wire

/* hw/rtl/theremin_wavetable_synth.sv */
// Theremin wavetable synthesizer top level: sequencer plus datapath.
// Tick beat: the result is built by the sixteen-step sequence of single-port
//   table reads and shared multiplies; no beat is accepted until idle again.
// Load beats: accepted whenever the sequencer is idle.
// Reset (sync, active low) clears filters, phase, volume smoothing and config,
//   except wave log2, set to 12; table contents are undefined until loaded.
`default_nettype none
module theremin_wavetable_synth #(
    parameter int WAVE_DEPTH = tws_pkg::WAVE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [2:0]    i_op,
    input  wire logic [11:0]   i_table_index,
    input  wire logic [31:0]   i_table_data,
    input  wire logic [15:0]   i_pitch_capture,
    input  wire logic [15:0]   i_vol_capture,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic signed [15:0] o_dac_sample
);
    import tws_pkg::*;

    // command bundle: current step, input beat accepted, output register load
    t_cmd cmd;

    // sequencer: idles for loads, walks the tick steps, holds the last step
    // until the output register is free
    tws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    // datapath: tables, period filters, pitch and volume lookups, wave
    // interpolation, volume scaling, shaping and output saturation
    tws_datapath #(
        .WAVE_DEPTH (WAVE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_table_index   (i_table_index),
        .i_table_data    (i_table_data),
        .i_pitch_capture (i_pitch_capture),
        .i_vol_capture   (i_vol_capture),
        .o_dac_sample    (o_dac_sample)
    );
endmodule
`default_nettype wire

/* dv/tb_theremin_wavetable_synth.sv */
// Self-checking testbench for theremin_wavetable_synth: a table-driven directed pass and
// random tick/load traffic, each output sample checked against an in-bench model of the synth.
// Depends on tws_pkg and the theremin_wavetable_synth RTL only.
`timescale 1ns / 100ps
module tb_theremin_wavetable_synth;
    import tws_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RAND_PER_PHASE = 340;
    localparam int NUM_PHASES = 6;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES = 400;

    // op codes the block has to ignore
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = CFG_PITCH_OFFSET;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_op = OP_TICK;
    logic [11:0]        i_table_index = '0;
    logic [31:0]        i_table_data = '0;
    logic [15:0]        i_pitch_capture = '0;
    logic [15:0]        i_vol_capture = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_dac_sample;

    theremin_wavetable_synth u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_table_index   (i_table_index),
        .i_table_data    (i_table_data),
        .i_pitch_capture (i_pitch_capture),
        .i_vol_capture   (i_vol_capture),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_dac_sample    (o_dac_sample)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Synth model state: config, filters, phase, volume smoothing, tables
    // ------------------------------------------------------------------
    logic signed [31:0] cfg_pitch_off = '0;
    logic signed [31:0] cfg_vol_off = '0;
    logic [3:0]         cfg_wave_log2 = 4'd12;
    logic               cfg_shaping = 1'b0;

    logic [15:0] last_pitch_stamp = '0;
    logic [15:0] last_vol_stamp = '0;
    longint      pitch_filt = 0;
    longint      vol_filt = 0;
    longint      pitch_val = 0;
    longint      vol_val = 0;
    logic [31:0] phase_acc = '0;
    logic [31:0] vol_acc = '0;
    logic [31:0] vol_sm = '0;
    logic [28:0] pitch_tab [PITCH_TABLE_DEPTH];
    logic [9:0]  vol_tab [VOL_TABLE_DEPTH];
    int          wave_tab [WAVE_DEPTH_DEF];
    int          shape_tab [SHAPE_TABLE_DEPTH];

    logic signed [15:0] dac_expected [$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   idle_en = 1'b1;
    int   hold_reqs = 0;
    int   hold_done = 0;
    int   hold_left = 0;

    // stimulus stamps kept by the sender, advanced by a period per tick
    logic [15:0] p_stamp = '0;
    logic [15:0] v_stamp = '0;

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [31:0] msb_pos(input logic [31:0] v);
        logic [31:0] e;
        e = 0;
        for (int k = 1; k < 32; k++) if ((v >> k) != 0) e = k;
        return e;
    endfunction

    // 23 fraction bits below the leading one, truncated
    function automatic logic [31:0] mantissa23(input logic [31:0] v, input logic [31:0] e);
        logic [31:0] r;
        r = v - (32'd1 << e);
        return (e >= 23) ? (r >> (e - 23)) : (r << (23 - e));
    endfunction

    task automatic track_period(inout longint filt, input logic [15:0] stamp,
                                input logic [15:0] last);
        logic [15:0] d;
        logic [31:0] period;
        longint      target;
        longint      diff;
        d = stamp - last;
        period = {16'd0, d};
        if (period < 2000) period = period * 2;   // short periods count double
        if (period == 0) return;                  // equal stamps: filter holds
        target = sat32(longint'($signed(16'(period - 2048))) * 1048576);
        diff = sat32(target - filt);
        filt = sat32(filt + diff / 1024);
    endtask

    task automatic synth_apply_beat(input logic [2:0] op, input logic [11:0] idx,
                                    input logic [31:0] data, input logic [15:0] pc,
                                    input logic [15:0] vc, output bit has_dac,
                                    output logic signed [15:0] dac);
        logic [31:0] e, f, ti, w, vol, level, mask, lgv, u;
        logic [63:0] pa, pb, va, vb;
        int          a, b, interp, wav;
        longint      res;
        has_dac = 1'b0;
        dac = '0;
        case (op)
            OP_LOAD_PITCH: if (idx < PITCH_TABLE_DEPTH) pitch_tab[idx] = data[28:0];
            OP_LOAD_VOL:   if (idx < VOL_TABLE_DEPTH) vol_tab[idx] = data[9:0];
            OP_LOAD_WAVE:  wave_tab[idx] = int'($signed(data[15:0]));
            OP_LOAD_SHAPE: if (idx < SHAPE_TABLE_DEPTH) shape_tab[idx] = int'($signed(data[15:0]));
            OP_TICK: begin
                // phase step from last tick's pitch value; no advance when not positive
                if (pitch_val >= 1) begin
                    e = msb_pos(pitch_val[31:0]);
                    f = mantissa23(pitch_val[31:0], e);
                    ti = (e << 6) | (f >> 17);
                    w = (f & 32'h1FFFF) >> 2;
                    pa = (ti < PITCH_TABLE_DEPTH) ? 64'(pitch_tab[ti]) : 64'd0;
                    pb = (ti + 1 < PITCH_TABLE_DEPTH) ? 64'(pitch_tab[ti + 1]) : 64'd0;
                    phase_acc = phase_acc + 32'((pa * (32768 - w) + pb * w) >> 15);
                end
                // volume: clamp, log-indexed lookup, first-order smoothing
                vol = (vol_val < 1) ? 32'd1 : ((vol_val > 32767) ? 32'd32767 : vol_val[31:0]);
                e = msb_pos(vol);
                f = mantissa23(vol, e);
                ti = (e << 6) | (f >> 17);
                w = f & 32'h1FFFF;
                va = (ti < VOL_TABLE_DEPTH) ? 64'(vol_tab[ti]) : 64'd0;
                vb = (ti + 1 < VOL_TABLE_DEPTH) ? 64'(vol_tab[ti + 1]) : 64'd0;
                level = 32'((va * (131072 - w) + vb * w) >> 17);
                vol_acc = (vol_acc + level - vol_sm) & 32'h3FFFFF;
                vol_sm = (vol_acc / 1024) & 32'h7FF;
                // wavetable read, wrap mask capped at the table size
                lgv = (cfg_wave_log2 > 12) ? 32'd12 : 32'(cfg_wave_log2);
                mask = ((32'd1 << lgv) - 1) & (WAVE_DEPTH_DEF - 1);
                ti = phase_acc >> 20;
                w = (phase_acc >> 12) & 32'hFF;
                a = wave_tab[ti & mask];
                b = wave_tab[(ti + 1) & mask];
                interp = a + ((b - a) * int'(w)) / 256;
                wav = int'((longint'(interp) * longint'(vol_sm)) / 1024);
                if (cfg_shaping) begin
                    u = 32'(wav + 32768);
                    ti = u / 64;
                    w = u & 32'h3F;
                    a = (ti < SHAPE_TABLE_DEPTH) ? shape_tab[ti] : 0;
                    b = (ti + 1 < SHAPE_TABLE_DEPTH) ? shape_tab[ti + 1] : 0;
                    res = (longint'(a) * 64 + longint'(b - a) * longint'(w)) / 64;
                end else begin
                    res = wav;
                end
                if (res > 32767) res = 32767;
                if (res < -32768) res = -32768;
                dac = res[15:0];
                has_dac = 1'b1;
                // periods from this tick feed the next one
                track_period(pitch_filt, pc, last_pitch_stamp);
                track_period(vol_filt, vc, last_vol_stamp);
                pitch_val = sat32(sat32(pitch_filt - longint'(cfg_pitch_off)) * 8);
                vol_val = sat32(vol_filt - longint'(cfg_vol_off)) / 4096;
                last_pitch_stamp = pc;
                last_vol_stamp = vc;
            end
            default: ;   // unused ops: no effect
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0d] mismatch: %s", cycles, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Sender: random gaps, then hold the beat until it is taken
    // ------------------------------------------------------------------
    task automatic offer_beat(input logic [2:0] op, input logic [11:0] idx,
                              input logic [31:0] data, input logic [15:0] pc,
                              input logic [15:0] vc, input bit typed,
                              input logic signed [15:0] typed_dac);
        bit                 stalled;
        bit                 has;
        logic signed [15:0] d;
        while (idle_en && $urandom_range(99) < 37) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_table_index <= idx;
        i_table_data <= data;
        i_pitch_capture <= pc;
        i_vol_capture <= vc;
        do begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
        end while (stalled);
        synth_apply_beat(op, idx, data, pc, vc, has, d);
        if (has) dac_expected.push_back(typed ? typed_dac : d);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (dac_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PITCH_OFFSET: cfg_pitch_off = data;
            CFG_VOL_OFFSET:   cfg_vol_off = data;
            CFG_WAVE_LOG2:    cfg_wave_log2 = data[3:0];
            default:          cfg_shaping = data[0];
        endcase
    endtask

    // mostly plausible periods, some noise and some repeated stamps
    function automatic logic [15:0] next_period();
        int r;
        r = $urandom_range(99);
        if (r < 75) return 16'($urandom_range(1800, 4500));
        if (r < 85) return 16'd0;
        return 16'($urandom_range(65535));
    endfunction

    task automatic random_beat;
        int r;
        r = $urandom_range(99);
        if (r < 72) begin
            p_stamp = p_stamp + next_period();
            v_stamp = v_stamp + next_period();
            offer_beat(OP_TICK, 12'($urandom), $urandom, p_stamp, v_stamp, 1'b0, '0);
        end else if (r < 94) begin
            offer_beat(3'($urandom_range(OP_LOAD_PITCH, OP_LOAD_SHAPE)), 12'($urandom),
                       $urandom, 16'($urandom), 16'($urandom), 1'b0, '0);
        end else begin
            offer_beat(3'($urandom_range(OP_RSVD5, OP_RSVD7)), 12'($urandom), $urandom,
                       16'($urandom), 16'($urandom), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed rows. The first tick after reset sees smoothed volume zero,
    // so its sample is zero whatever the tables hold.
    // ------------------------------------------------------------------
    typedef struct {
        logic [2:0]         op;
        logic [11:0]        idx;
        logic [31:0]        data;
        logic [15:0]        pc;
        logic [15:0]        vc;
        bit                 typed;
        logic signed [15:0] dac;
    } t_stim_row;

    localparam int NUM_ROWS = 20;
    t_stim_row stim_rows [NUM_ROWS] = '{
        '{OP_TICK,       12'd0,    32'd0,          16'd0,     16'd0,     1'b1, 16'sd0},
        '{OP_TICK,       12'd0,    32'd0,          16'hFFFF,  16'hFFFF,  1'b0, 16'sd0},
        '{OP_TICK,       12'd0,    32'd0,          16'hFFFF,  16'hFFFF,  1'b0, 16'sd0},
        '{OP_TICK,       12'd0,    32'd0,          16'd999,   16'd1,     1'b0, 16'sd0},
        '{OP_TICK,       12'd0,    32'd0,          16'd3499,  16'd2000,  1'b0, 16'sd0},
        '{OP_TICK,       12'd0,    32'd0,          16'd5547,  16'd4048,  1'b0, 16'sd0},
        '{OP_LOAD_PITCH, 12'd4095, 32'hFFFFFFFF,   16'd0,     16'd0,     1'b0, 16'sd0},
        '{OP_LOAD_PITCH, 12'd2048, 32'hFFFFFFFF,   16'd0,     16'd0,     1'b0, 16'sd0},
        '{OP_LOAD_VOL,   12'd1024, 32'hFFFFFFFF,   16'd0,     16'd0,     1'b0, 16'sd0},
        '{OP_LOAD_SHAPE, 12'd1025, 32'hFFFFFFFF,   16'd0,     16'd0,     1'b0, 16'sd0},
        '{OP_LOAD_WAVE,  12'd4095, 32'h00008000,   16'd0,     16'd0,     1'b0, 16'sd0},
        '{OP_LOAD_WAVE,  12'd0,    32'hFFFF7FFF,   16'd0,     16'd0,     1'b0, 16'sd0},
        '{OP_LOAD_SHAPE, 12'd1024, 32'h00007FFF,   16'd0,     16'd0,     1'b0, 16'sd0},
        '{OP_RSVD5,      12'd0,    32'd0,          16'd0,     16'd0,     1'b0, 16'sd0},
        '{OP_RSVD6,      12'd4095, 32'hFFFFFFFF,   16'hFFFF,  16'hFFFF,  1'b0, 16'sd0},
        '{OP_RSVD7,      12'd0,    32'd0,          16'd0,     16'd0,     1'b0, 16'sd0},
        '{OP_TICK,       12'd0,    32'd0,          16'd8000,  16'd7000,  1'b0, 16'sd0},
        '{OP_TICK,       12'd0,    32'd0,          16'd10600, 16'd9100,  1'b0, 16'sd0},
        '{OP_TICK,       12'd0,    32'd0,          16'd0,     16'd65535, 1'b0, 16'sd0},
        '{OP_TICK,       12'd0,    32'd0,          16'd2500,  16'd1500,  1'b0, 16'sd0}
    };

    // ------------------------------------------------------------------
    // Receiver: random stall, plus long hold-offs on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_done != hold_reqs) begin
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= idle_en && ($urandom_range(99) < 37);
        end
    end

    // Result checker: a beat is taken at the edge after this sample point
    always @(negedge i_clk) begin : check_results
        logic signed [15:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (dac_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %0d", o_dac_sample));
            end else begin
                want = dac_expected.pop_front();
                if (o_dac_sample !== want)
                    report_mismatch($sformatf("dac_sample got %0d want %0d",
                                              o_dac_sample, want));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every table entry is written before any tick can read it
        for (int k = 0; k < WAVE_DEPTH_DEF; k++)
            offer_beat(OP_LOAD_WAVE, 12'(k), $urandom, '0, '0, 1'b0, '0);
        for (int k = 0; k < PITCH_TABLE_DEPTH; k++)
            offer_beat(OP_LOAD_PITCH, 12'(k), $urandom, '0, '0, 1'b0, '0);
        for (int k = 0; k < VOL_TABLE_DEPTH; k++)
            offer_beat(OP_LOAD_VOL, 12'(k), $urandom, '0, '0, 1'b0, '0);
        for (int k = 0; k < SHAPE_TABLE_DEPTH; k++)
            offer_beat(OP_LOAD_SHAPE, 12'(k), $urandom, '0, '0, 1'b0, '0);

        for (int k = 0; k < NUM_ROWS; k++)
            offer_beat(stim_rows[k].op, stim_rows[k].idx, stim_rows[k].data,
                       stim_rows[k].pc, stim_rows[k].vc, stim_rows[k].typed,
                       stim_rows[k].dac);
        p_stamp = 16'd2500;
        v_stamp = 16'd1500;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(CFG_PITCH_OFFSET, 32'd0);
                    write_reg(CFG_VOL_OFFSET, 32'd0);
                    write_reg(CFG_WAVE_LOG2, 32'd12);
                    write_reg(CFG_USE_SHAPING, 32'd0);
                end
                1: begin
                    // huge pitch value, volume clamped low, single wave entry
                    write_reg(CFG_PITCH_OFFSET, 32'h8000_0000);
                    write_reg(CFG_VOL_OFFSET, 32'h7FFF_FFFF);
                    write_reg(CFG_WAVE_LOG2, 32'd0);
                    write_reg(CFG_USE_SHAPING, 32'd1);
                end
                2: begin
                    // negative pitch value freezes phase; volume clamped high
                    write_reg(CFG_PITCH_OFFSET, 32'h7FFF_FFFF);
                    write_reg(CFG_VOL_OFFSET, 32'h8000_0000);
                    write_reg(CFG_WAVE_LOG2, 32'd15);
                    write_reg(CFG_USE_SHAPING, 32'd1);
                end
                3: begin
                    write_reg(CFG_PITCH_OFFSET, $urandom_range(0, 400) << 20);
                    write_reg(CFG_VOL_OFFSET, $urandom);
                    write_reg(CFG_WAVE_LOG2, $urandom_range(1, 12));
                    write_reg(CFG_USE_SHAPING, $urandom_range(1));
                end
                4: begin
                    write_reg(CFG_PITCH_OFFSET, $urandom);
                    write_reg(CFG_VOL_OFFSET, $urandom);
                    write_reg(CFG_WAVE_LOG2, $urandom);
                    write_reg(CFG_USE_SHAPING, $urandom);
                end
                default: begin
                    write_reg(CFG_PITCH_OFFSET, 32'd0);
                    write_reg(CFG_VOL_OFFSET, $urandom);
                    write_reg(CFG_WAVE_LOG2, 32'd13);
                    write_reg(CFG_USE_SHAPING, 32'd0);
                end
            endcase
            idle_en = (ph != 4);          // phase 4 runs back to back
            if (ph == 3) hold_reqs++;     // receiver backs off, block fills up
            for (int k = 0; k < RAND_PER_PHASE; k++) random_beat();
        end

        drain();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
